FILE: rtl/core/dfsmg_pkg.sv
// Package for the depth-first maze generator: cell bit masks, operation and
// direction codes, the sequencer state type and a small modulo-3 helper.
// No dependencies.
package dfsmg_pkg;

    // Cell store bits: four open paths and the visited mark.
    localparam logic [4:0] PATH_N    = 5'h01;
    localparam logic [4:0] PATH_E    = 5'h02;
    localparam logic [4:0] PATH_S    = 5'h04;
    localparam logic [4:0] PATH_W    = 5'h08;
    localparam logic [4:0] VISITED   = 5'h10;
    localparam logic [3:0] PATH_MASK = 4'hf;

    // Operation codes of an input item.
    localparam logic [1:0] OP_CARVE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Direction codes, also the order in which neighbors are listed.
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_E,
        S_RD_S,
        S_RD_W,
        S_RD_TOP,
        S_DECIDE,
        S_WR_NBR,
        S_POP,
        S_RD_CELL,
        S_DONE,
        S_CLEAR
    } t_state;

    // Remainder of a 16-bit word by three: base-4 digits all weigh one.
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = 5'd0;
        for (int i = 0; i < 8; i++) begin
            s = s + {3'b000, v[2*i +: 2]};
        end
        t = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'b00, s[4]};
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

FILE: rtl/core/dfs_maze_generator.sv
// Depth-first backtracking maze generator: cell store and coordinate stack in
// synchronous memories, driven by a read-modify-write sequencer. Uses dfsmg_pkg.
// One item at a time: a new input item is taken only once the last result has
// been handed to the output register. The cell store port (five reads, two writes
// per carve) sets the carve rate.
// Reset and restart run a clearing pass over the cell store, during which no
// input item is taken.
module dfs_maze_generator
    import dfsmg_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_random_value,
    input  logic [5:0]  i_cell_x,
    input  logic [5:0]  i_cell_y,
    // Result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_from_x,
    output logic [5:0]  o_from_y,
    output logic        o_carved,
    output logic [1:0]  o_direction,
    output logic        o_backtracked,
    output logic        o_finished,
    output logic [3:0]  o_cell_paths,
    output logic        o_cell_visited
);

    localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = 2 * CW;
    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int SAW   = $clog2(CELLS);
    localparam int SPW   = $clog2(CELLS + 1);
    localparam int CMPW  = (CW + 1 > 7) ? CW + 1 : 7;

    // Memories.
    logic [4:0]      r_cell_mem [2**AW];
    logic [AW-1:0]   r_stack_mem [CELLS];
    logic [4:0]      r_cell_rd;
    logic [AW-1:0]   r_stack_rd;

    logic            cell_we;
    logic [AW-1:0]   cell_wa;
    logic [4:0]      cell_wd;
    logic [AW-1:0]   cell_ra;
    logic            stk_we;
    logic [SAW-1:0]  stk_wa;
    logic [AW-1:0]   stk_wd;
    logic [SAW-1:0]  stk_ra;

    // Control state.
    t_state          r_state, n_state;
    logic [6:0]      r_width, r_height;
    logic [SPW-1:0]  r_sp, n_sp;
    logic [CW-1:0]   r_top_x, n_top_x, r_top_y, n_top_y;
    logic [AW-1:0]   r_clr, n_clr;
    logic            r_clr_pend, n_clr_pend;
    logic            r_out_valid, n_out_valid;

    // Work and result registers.
    logic [15:0]     r_rnd, n_rnd;
    logic [1:0]      r_rnd3, n_rnd3;
    logic            r_in_grid, n_in_grid;
    logic [3:0][4:0] r_nbr, n_nbr;
    logic [4:0]      r_nbr_wd, n_nbr_wd;
    logic [CW-1:0]   r_nx, n_nx, r_ny, n_ny;
    logic [CW-1:0]   r_res_fx, n_res_fx, r_res_fy, n_res_fy;
    logic            r_res_carved, n_res_carved;
    logic [1:0]      r_res_dir, n_res_dir;
    logic            r_res_back, n_res_back;
    logic            r_res_fin, n_res_fin;
    logic [3:0]      r_res_paths, n_res_paths;
    logic            r_res_vis, n_res_vis;

    // Output register.
    logic [CW-1:0]   r_o_fx, n_o_fx, r_o_fy, n_o_fy;
    logic            r_o_carved, n_o_carved;
    logic [1:0]      r_o_dir, n_o_dir;
    logic            r_o_back, n_o_back;
    logic            r_o_fin, n_o_fin;
    logic [3:0]      r_o_paths, n_o_paths;
    logic            r_o_vis, n_o_vis;

    // Clamped grid bounds and neighbor tests of the top cell.
    logic [CMPW-1:0] w_ext, h_ext, w_eff, h_eff;
    logic [3:0]      cand;
    logic [2:0]      cand_cnt;
    logic [1:0]      pick_idx;
    logic [1:0]      pick_dir;
    logic [SPW-1:0]  sp_less2;

    assign w_ext = CMPW'(r_width);
    assign h_ext = CMPW'(r_height);
    assign w_eff = (w_ext < CMPW'(2)) ? CMPW'(2)
                 : (w_ext > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : w_ext;
    assign h_eff = (h_ext < CMPW'(2)) ? CMPW'(2)
                 : (h_ext > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : h_ext;

    assign cand[DIR_N] = (r_top_y != '0) && !r_nbr[DIR_N][4];
    assign cand[DIR_E] = (CMPW'(r_top_x) + CMPW'(1) < w_eff) && !r_nbr[DIR_E][4];
    assign cand[DIR_S] = (CMPW'(r_top_y) + CMPW'(1) < h_eff) && !r_nbr[DIR_S][4];
    assign cand[DIR_W] = (r_top_x != '0) && !r_nbr[DIR_W][4];

    assign cand_cnt = {2'b00, cand[0]} + {2'b00, cand[1]}
                    + {2'b00, cand[2]} + {2'b00, cand[3]};
    assign sp_less2 = r_sp - SPW'(2);

    // Index of the chosen candidate: random word modulo the candidate count.
    always_comb begin
        case (cand_cnt)
            3'd1:    pick_idx = 2'd0;
            3'd2:    pick_idx = {1'b0, r_rnd[0]};
            3'd3:    pick_idx = r_rnd3;
            default: pick_idx = r_rnd[1:0];
        endcase
    end

    // Direction of the candidate at that index, in north-east-south-west order.
    always_comb begin
        logic [1:0] seen;
        logic       found;
        seen     = 2'd0;
        found    = 1'b0;
        pick_dir = DIR_N;
        for (int d = 0; d < 4; d++) begin
            if (cand[d]) begin
                if (!found && seen == pick_idx) begin
                    pick_dir = 2'(d);
                    found    = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end
    end

    // Cell store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cell_mem[cell_wa] <= cell_wd;
        end
        r_cell_rd <= r_cell_mem[cell_ra];
    end

    // Coordinate stack below and at the cached top entry.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack_mem[stk_wa] <= stk_wd;
        end
        r_stack_rd <= r_stack_mem[stk_ra];
    end

    // Sequencer: next state, memory controls and next register values.
    always_comb begin
        logic [4:0]    here_bit;
        logic [4:0]    there_bit;
        logic [CW-1:0] nx;
        logic [CW-1:0] ny;

        n_state      = r_state;
        n_sp         = r_sp;
        n_top_x      = r_top_x;
        n_top_y      = r_top_y;
        n_clr        = r_clr;
        n_clr_pend   = r_clr_pend;
        n_rnd        = r_rnd;
        n_rnd3       = r_rnd3;
        n_in_grid    = r_in_grid;
        n_nbr        = r_nbr;
        n_nbr_wd     = r_nbr_wd;
        n_nx         = r_nx;
        n_ny         = r_ny;
        n_res_fx     = r_res_fx;
        n_res_fy     = r_res_fy;
        n_res_carved = r_res_carved;
        n_res_dir    = r_res_dir;
        n_res_back   = r_res_back;
        n_res_fin    = r_res_fin;
        n_res_paths  = r_res_paths;
        n_res_vis    = r_res_vis;
        n_o_fx       = r_o_fx;
        n_o_fy       = r_o_fy;
        n_o_carved   = r_o_carved;
        n_o_dir      = r_o_dir;
        n_o_back     = r_o_back;
        n_o_fin      = r_o_fin;
        n_o_paths    = r_o_paths;
        n_o_vis      = r_o_vis;
        n_out_valid  = r_out_valid && !i_ready;

        here_bit  = PATH_N;
        there_bit = PATH_S;
        nx        = r_top_x;
        ny        = r_top_y;

        cell_we = 1'b0;
        cell_wa = {r_top_y, r_top_x};
        cell_wd = '0;
        cell_ra = {r_top_y - CW'(1), r_top_x};
        stk_we  = 1'b0;
        stk_wa  = r_sp[SAW-1:0];
        stk_wd  = '0;
        stk_ra  = sp_less2[SAW-1:0];

        case (r_state)
            // Take an item; the north neighbor read goes out at once.
            S_IDLE: begin
                if (i_valid) begin
                    n_res_fx     = (r_sp != '0) ? r_top_x : '0;
                    n_res_fy     = (r_sp != '0) ? r_top_y : '0;
                    n_res_carved = 1'b0;
                    n_res_dir    = DIR_N;
                    n_res_back   = 1'b0;
                    n_res_fin    = (r_sp == '0);
                    n_res_paths  = '0;
                    n_res_vis    = 1'b0;
                    case (i_operation)
                        OP_CARVE: begin
                            if (r_sp != '0) begin
                                n_rnd   = i_random_value;
                                n_rnd3  = mod3_16(i_random_value);
                                n_state = S_RD_E;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        OP_READ: begin
                            cell_ra   = {CW'(i_cell_y), CW'(i_cell_x)};
                            n_in_grid = (CMPW'(i_cell_x) < w_eff)
                                     && (CMPW'(i_cell_y) < h_eff);
                            n_state   = S_RD_CELL;
                        end
                        OP_RESTART: begin
                            n_sp       = SPW'(1);
                            n_top_x    = '0;
                            n_top_y    = '0;
                            n_res_fin  = 1'b0;
                            n_clr_pend = 1'b1;
                            n_state    = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            // Neighbor reads: each state issues one address and takes the data of the last.
            S_RD_E: begin
                cell_ra      = {r_top_y, r_top_x + CW'(1)};
                n_nbr[DIR_N] = r_cell_rd;
                n_state      = S_RD_S;
            end
            S_RD_S: begin
                cell_ra      = {r_top_y + CW'(1), r_top_x};
                n_nbr[DIR_E] = r_cell_rd;
                n_state      = S_RD_W;
            end
            S_RD_W: begin
                cell_ra      = {r_top_y, r_top_x - CW'(1)};
                n_nbr[DIR_S] = r_cell_rd;
                n_state      = S_RD_TOP;
            end
            S_RD_TOP: begin
                cell_ra      = {r_top_y, r_top_x};
                n_nbr[DIR_W] = r_cell_rd;
                n_state      = S_DECIDE;
            end
            // Top cell data is here: carve toward the chosen neighbor, or pop.
            S_DECIDE: begin
                if (cand_cnt != 3'd0) begin
                    case (pick_dir)
                        DIR_N: begin
                            ny = r_top_y - CW'(1);
                            here_bit = PATH_N;
                            there_bit = PATH_S;
                        end
                        DIR_E: begin
                            nx = r_top_x + CW'(1);
                            here_bit = PATH_E;
                            there_bit = PATH_W;
                        end
                        DIR_S: begin
                            ny = r_top_y + CW'(1);
                            here_bit = PATH_S;
                            there_bit = PATH_N;
                        end
                        default: begin
                            nx = r_top_x - CW'(1);
                            here_bit = PATH_W;
                            there_bit = PATH_E;
                        end
                    endcase
                    cell_we      = 1'b1;
                    cell_wd      = r_cell_rd | here_bit;
                    n_nbr_wd     = r_nbr[pick_dir] | there_bit | VISITED;
                    n_nx         = nx;
                    n_ny         = ny;
                    n_res_carved = 1'b1;
                    n_res_dir    = pick_dir;
                    if (r_sp < SPW'(CELLS)) begin
                        stk_we  = 1'b1;
                        stk_wd  = {ny, nx};
                        n_sp    = r_sp + SPW'(1);
                        n_top_x = nx;
                        n_top_y = ny;
                    end
                    n_state = S_WR_NBR;
                end else begin
                    n_sp       = r_sp - SPW'(1);
                    n_res_back = 1'b1;
                    n_res_fin  = (r_sp == SPW'(1));
                    n_state    = S_POP;
                end
            end
            S_WR_NBR: begin
                cell_we = 1'b1;
                cell_wa = {r_ny, r_nx};
                cell_wd = r_nbr_wd;
                n_state = S_DONE;
            end
            // The entry below the popped one becomes the cached top.
            S_POP: begin
                n_top_y = r_stack_rd[AW-1:CW];
                n_top_x = r_stack_rd[CW-1:0];
                n_state = S_DONE;
            end
            S_RD_CELL: begin
                if (r_in_grid) begin
                    n_res_paths = r_cell_rd[3:0] & PATH_MASK;
                    n_res_vis   = r_cell_rd[4];
                end
                n_state = S_DONE;
            end
            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_fx      = r_res_fx;
                    n_o_fy      = r_res_fy;
                    n_o_carved  = r_res_carved;
                    n_o_dir     = r_res_dir;
                    n_o_back    = r_res_back;
                    n_o_fin     = r_res_fin;
                    n_o_paths   = r_res_paths;
                    n_o_vis     = r_res_vis;
                    n_clr       = '0;
                    n_state     = r_clr_pend ? S_CLEAR : S_IDLE;
                end
            end
            // Clearing pass: start cell visited, all others zero, stack base reset.
            S_CLEAR: begin
                cell_we = 1'b1;
                cell_wa = r_clr;
                cell_wd = (r_clr == '0) ? VISITED : 5'h00;
                if (r_clr == '0) begin
                    stk_we = 1'b1;
                    stk_wa = '0;
                    stk_wd = '0;
                end
                n_clr = r_clr + AW'(1);
                if (&r_clr) begin
                    n_clr_pend = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= SPW'(1);
            r_top_x     <= '0;
            r_top_y     <= '0;
            r_clr       <= '0;
            r_clr_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sp        <= n_sp;
            r_top_x     <= n_top_x;
            r_top_y     <= n_top_y;
            r_clr       <= n_clr;
            r_clr_pend  <= n_clr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Work, result and output payload registers.
    always_ff @(posedge i_clk) begin
        r_rnd        <= n_rnd;
        r_rnd3       <= n_rnd3;
        r_in_grid    <= n_in_grid;
        r_nbr        <= n_nbr;
        r_nbr_wd     <= n_nbr_wd;
        r_nx         <= n_nx;
        r_ny         <= n_ny;
        r_res_fx     <= n_res_fx;
        r_res_fy     <= n_res_fy;
        r_res_carved <= n_res_carved;
        r_res_dir    <= n_res_dir;
        r_res_back   <= n_res_back;
        r_res_fin    <= n_res_fin;
        r_res_paths  <= n_res_paths;
        r_res_vis    <= n_res_vis;
        r_o_fx       <= n_o_fx;
        r_o_fy       <= n_o_fy;
        r_o_carved   <= n_o_carved;
        r_o_dir      <= n_o_dir;
        r_o_back     <= n_o_back;
        r_o_fin      <= n_o_fin;
        r_o_paths    <= n_o_paths;
        r_o_vis      <= n_o_vis;
    end

    // Configuration registers, written in the access phase of a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'd32;
            r_height <= 7'd32;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_WIDTH) begin
                r_width <= pwdata[6:0];
            end else begin
                r_height <= pwdata[6:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {25'd0, r_height} : {25'd0, r_width};

    // Ports.
    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_from_x       = 6'(r_o_fx);
    assign o_from_y       = 6'(r_o_fy);
    assign o_carved       = r_o_carved;
    assign o_direction    = r_o_dir;
    assign o_backtracked  = r_o_back;
    assign o_finished     = r_o_fin;
    assign o_cell_paths   = r_o_paths;
    assign o_cell_visited = r_o_vis;

endmodule
